// ===== hw/rtl/ghpd_pkg.sv =====
// Shared codes and widths for the grid point dedup block.
package ghpd_pkg;

  // Result status codes.
  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_MISS     = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Input kind codes.
  localparam logic KIND_QUERY  = 1'b0;
  localparam logic KIND_INSERT = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
  localparam logic [2:0] REG_SCALE_X   = 3'd3;
  localparam logic [2:0] REG_SCALE_Y   = 3'd4;
  localparam logic [2:0] REG_SCALE_Z   = 3'd5;
  localparam logic [2:0] REG_TOLERANCE = 3'd6;

  localparam int CoordW = 32;
  localparam int IdOutW = 12;

endpackage

// ===== hw/rtl/grid_hash_point_dedup_top.sv =====
// Top level of the uniform grid point dedup locator.
//
// Channel   Dir  Payload
// s_axis    in   tdata {z,y,x} 96b, tuser kind
// m_axis    out  tdata {pad,id,status} 16b
// cfg       in   index 3b, data 32b
//
// An item passes through these steps and then one output beat: the accept step, the
// cell index one axis a cycle through one shared 32x32 multiplier (S_CELL), forming
// the cell address, the bucket count read (S_FILL, S_SLOT), then four steps per
// stored id scanned (slot read, id capture, point read, compare), and a decide step
// that a match skips.
// After reset a clearing pass walks the bucket count memory, one cell a cycle;
// no item is taken during it.
// The input is not ready while an item is at work or a result waits.
module grid_hash_point_dedup_top #(
  parameter int GRID_X       = 16,
  parameter int GRID_Y       = 16,
  parameter int GRID_Z       = 16,
  parameter int BUCKET_SLOTS = 8,
  parameter int MAX_POINTS   = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // coord_x, coord_y, coord_z
  input  logic        s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status, point_id, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int Cells  = GRID_X * GRID_Y * GRID_Z;
  localparam int CellW  = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int SlotW  = (BUCKET_SLOTS > 1) ? $clog2(BUCKET_SLOTS) : 1;
  localparam int FillW  = $clog2(BUCKET_SLOTS + 1);
  localparam int IdW    = $clog2(MAX_POINTS);
  localparam int NextW  = IdW + 1;
  localparam int EntW   = CellW + SlotW;
  localparam int Entries = Cells * (2 ** SlotW);
  localparam int GxW    = (GRID_X > 1) ? $clog2(GRID_X) : 1;
  localparam int GyW    = (GRID_Y > 1) ? $clog2(GRID_Y) : 1;
  localparam int GzW    = (GRID_Z > 1) ? $clog2(GRID_Z) : 1;
  localparam int IdOutWv = ghpd_pkg::IdOutW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CELL, S_CIDX, S_FILL, S_SLOT, S_SLOTW,
    S_PT, S_PTW, S_CMP, S_DECIDE, S_OUT
  } state_t;

  state_t state;

  // Configuration registers.
  logic signed [31:0] origin [3];
  logic        [31:0] scale [3];
  logic        [15:0] tol;

  // Item registers.
  logic               kind;
  logic signed [31:0] coord [3];
  logic [1:0]         axis;
  logic [7:0]         cidx [3];
  logic [CellW-1:0]   cell_addr;
  logic [FillW-1:0]   fill;
  logic [FillW-1:0]   slot;
  logic [IdW-1:0]     cur_id;
  logic [NextW-1:0]   next_id;
  logic [CellW-1:0]   clr_addr;
  logic [1:0]         status;
  logic [IdOutWv-1:0] out_id;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '{default: '0};
      scale  <= '{default: 32'd65536};
      tol    <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        ghpd_pkg::REG_ORIGIN_X:  origin[0] <= cfg_data;
        ghpd_pkg::REG_ORIGIN_Y:  origin[1] <= cfg_data;
        ghpd_pkg::REG_ORIGIN_Z:  origin[2] <= cfg_data;
        ghpd_pkg::REG_SCALE_X:   scale[0]  <= cfg_data;
        ghpd_pkg::REG_SCALE_Y:   scale[1]  <= cfg_data;
        ghpd_pkg::REG_SCALE_Z:   scale[2]  <= cfg_data;
        ghpd_pkg::REG_TOLERANCE: tol       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Shared cell unit: offset, one multiply, clamp; one axis per cycle.
  logic signed [32:0] diff;
  logic        [63:0] prod;
  logic        [31:0] phigh;
  logic        [8:0]  lim;
  logic        [7:0]  cell_sel;
  always_comb begin
    diff  = 33'(coord[axis]) - 33'(origin[axis]);
    prod  = 64'(diff[31:0]) * 64'(scale[axis]);
    // A positive offset fits in 32 bits, so the high word is the cell.
    phigh = prod[63:32];
    case (axis)
      2'd0:    lim = 9'(GRID_X - 1);
      2'd1:    lim = 9'(GRID_Y - 1);
      default: lim = 9'(GRID_Z - 1);
    endcase
    if (diff[32] || diff == 0) cell_sel = 8'd0;
    else if (phigh > 32'(lim)) cell_sel = lim[7:0];
    else cell_sel = phigh[7:0];
  end

  // Memories.
  logic             fill_we;
  logic [CellW-1:0] fill_waddr;
  logic [FillW-1:0] fill_wdata, fill_rdata;
  logic             ent_we;
  logic [EntW-1:0]  ent_waddr, ent_raddr;
  logic [IdW-1:0]   ent_rdata;
  logic             pt_we;
  logic [IdW-1:0]   pt_raddr;
  logic [31:0]      pt_rdata [3];

  ghpd_ram #(.Width(FillW), .Depth(Cells)) u_fill (
    .clk, .we(fill_we), .waddr(fill_waddr), .wdata(fill_wdata),
    .raddr(cell_addr), .rdata(fill_rdata));
  ghpd_ram #(.Width(IdW), .Depth(Entries)) u_ent (
    .clk, .we(ent_we), .waddr(ent_waddr), .wdata(next_id[IdW-1:0]),
    .raddr(ent_raddr), .rdata(ent_rdata));
  for (genvar a = 0; a < 3; a++) begin : g_pt
    ghpd_ram #(.Width(32), .Depth(MAX_POINTS)) u_pt (
      .clk, .we(pt_we), .waddr(next_id[IdW-1:0]), .wdata(coord[a]),
      .raddr(pt_raddr), .rdata(pt_rdata[a]));
  end

  logic ins_ok;
  assign ins_ok = (kind == ghpd_pkg::KIND_INSERT) && (fill < FillW'(BUCKET_SLOTS))
                  && (next_id < NextW'(MAX_POINTS)) && (state == S_DECIDE);
  assign fill_we    = (state == S_CLEAR) || ins_ok;
  assign fill_waddr = (state == S_CLEAR) ? clr_addr : cell_addr;
  assign fill_wdata = (state == S_CLEAR) ? '0 : fill + 1'b1;
  assign ent_we     = ins_ok;
  assign ent_waddr  = {cell_addr, slot[SlotW-1:0]};
  assign ent_raddr  = {cell_addr, slot[SlotW-1:0]};
  assign pt_we      = ins_ok;
  assign pt_raddr   = cur_id;

  // Point compare: exact for a query, within tolerance for an insert.
  logic hit;
  logic [2:0] ax_hit;
  logic signed [32:0] pd;
  logic [32:0] ad;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pd = 33'(coord[a]) - 33'($signed(pt_rdata[a]));
      ad = pd[32] ? 33'(-pd) : 33'(pd);
      ax_hit[a] = (kind == ghpd_pkg::KIND_QUERY) ? (pd == 0) : (ad < 33'(tol));
    end
    hit = &ax_hit;
  end

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = (state == S_OUT);
  assign m_axis_tdata  = {2'b00, out_id, status};

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      next_id  <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == CellW'(Cells - 1)) state <= S_IDLE;
        end
        S_IDLE: if (s_axis_tvalid) begin
          kind     <= s_axis_tuser;
          coord[0] <= s_axis_tdata[31:0];
          coord[1] <= s_axis_tdata[63:32];
          coord[2] <= s_axis_tdata[95:64];
          axis     <= 2'd0;
          state    <= S_CELL;
        end
        S_CELL: begin
          cidx[axis] <= cell_sel;
          axis <= (axis == 2'd2) ? 2'd0 : axis + 1'b1;
          if (axis == 2'd2) state <= S_CIDX;
        end
        S_CIDX: begin
          cell_addr <= CellW'(32'(cidx[0][GxW-1:0]) + 32'(cidx[1][GyW-1:0]) * GRID_X
                       + 32'(cidx[2][GzW-1:0]) * (GRID_X * GRID_Y));
          slot  <= '0;
          state <= S_FILL;
        end
        S_FILL: state <= S_SLOT;
        S_SLOT: begin
          fill  <= (fill_rdata > FillW'(BUCKET_SLOTS)) ? FillW'(BUCKET_SLOTS)
                   : fill_rdata;
          state <= S_DECIDE;
          if (slot < fill_rdata && slot < FillW'(BUCKET_SLOTS)) state <= S_SLOTW;
        end
        S_SLOTW: state <= S_PT;
        S_PT: begin
          cur_id <= ent_rdata;
          state  <= S_PTW;
        end
        S_PTW: state <= S_CMP;
        S_CMP: begin
          if (hit) begin
            status <= ghpd_pkg::ST_FOUND;
            out_id <= IdOutWv'(cur_id);
            state  <= S_OUT;
          end else begin
            slot  <= slot + 1'b1;
            state <= (slot + 1'b1 < fill) ? S_SLOTW : S_DECIDE;
          end
        end
        S_DECIDE: begin
          state  <= S_OUT;
          out_id <= '0;
          if (kind == ghpd_pkg::KIND_QUERY) status <= ghpd_pkg::ST_MISS;
          else if (!ins_ok) status <= ghpd_pkg::ST_FULL;
          else begin
            status  <= ghpd_pkg::ST_INSERTED;
            out_id  <= IdOutWv'(next_id);
            next_id <= next_id + 1'b1;
          end
        end
        S_OUT: if (m_axis_tready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/ghpd_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module ghpd_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the grid point dedup locator.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GX = 16, GY = 16, GZ = 16;
  localparam int SLOTS = 8;
  localparam int POINTS = 4096;
  localparam int CELLS = GX * GY * GZ;
  localparam int SETTLE = 60;
  localparam int LIMIT = 400000;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_item_t;

  typedef struct {
    logic [1:0]  status;
    logic [11:0] id;
  } lookup_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // coord_x, coord_y, coord_z
  logic        s_axis_tuser = 1'b0; // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // status, point_id, zero pad
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        cfg_ready;

  grid_hash_point_dedup_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Mirror of the block configuration.
  logic signed [31:0] org_x = 0, org_y = 0, org_z = 0;
  logic [31:0] scl_x = 32'h10000, scl_y = 32'h10000, scl_z = 32'h10000;
  logic [15:0] tol = 16'd1;

  // Mirror of the point store and the buckets.
  logic signed [31:0] pt_x [POINTS];
  logic signed [31:0] pt_y [POINTS];
  logic signed [31:0] pt_z [POINTS];
  int                 bucket_count [CELLS];
  logic [11:0]        bucket_ids [CELLS*SLOTS];
  int                 next_id = 0;

  point_item_t    pending_items [$];
  lookup_result_t expected_results [$];
  point_item_t    known_points [$];
  point_item_t    cur_item;

  int  errors = 0;
  int  cycles = 0;
  int  sent = 0;
  int  status_seen [4];
  bit  sender_burst = 0;
  bit  sink_burst = 0;
  int  send_gap = 0;
  int  sink_stall = 0;

  initial begin
    foreach (bucket_count[i]) bucket_count[i] = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
  end

  // Cell index on one axis, clamped to the grid.
  function automatic int axis_cell(logic signed [31:0] c, logic signed [31:0] org,
                                   logic [31:0] scl, int cells);
    longint d;
    logic [63:0] p;
    d = longint'(c) - longint'(org);
    if (d <= 0) return 0;
    p = (64'(d) * {32'b0, scl}) >> 32;
    if (p > 64'(cells - 1)) return cells - 1;
    return int'(p);
  endfunction

  function automatic bit close_on_axis(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d < longint'(tol);
  endfunction

  // Look the point up in its bucket and update the store as the block would.
  function automatic lookup_result_t lookup_point(point_item_t it);
    lookup_result_t r;
    int cell_idx, fill, id;
    bit hit;
    cell_idx = axis_cell(it.x, org_x, scl_x, GX) + axis_cell(it.y, org_y, scl_y, GY) * GX
             + axis_cell(it.z, org_z, scl_z, GZ) * GX * GY;
    fill = bucket_count[cell_idx];
    for (int i = 0; i < fill; i++) begin
      id = bucket_ids[cell_idx*SLOTS + i];
      if (it.kind == ghpd_pkg::KIND_QUERY)
        hit = pt_x[id] == it.x && pt_y[id] == it.y && pt_z[id] == it.z;
      else
        hit = close_on_axis(it.x, pt_x[id]) && close_on_axis(it.y, pt_y[id])
           && close_on_axis(it.z, pt_z[id]);
      if (hit) begin
        r.status = ghpd_pkg::ST_FOUND;
        r.id = id[11:0];
        return r;
      end
    end
    r.id = '0;
    if (it.kind == ghpd_pkg::KIND_QUERY) begin
      r.status = ghpd_pkg::ST_MISS;
      return r;
    end
    if (fill >= SLOTS || next_id >= POINTS) begin
      r.status = ghpd_pkg::ST_FULL;
      return r;
    end
    pt_x[next_id] = it.x;
    pt_y[next_id] = it.y;
    pt_z[next_id] = it.z;
    bucket_ids[cell_idx*SLOTS + fill] = next_id[11:0];
    bucket_count[cell_idx] = fill + 1;
    r.status = ghpd_pkg::ST_INSERTED;
    r.id = next_id[11:0];
    next_id++;
    return r;
  endfunction

  function automatic int draw_wait(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Input driver: predicts each accepted beat, then presents the next item.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(lookup_point(cur_item));
        sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          s_axis_tdata <= {cur_item.z, cur_item.y, cur_item.x};
          s_axis_tuser <= cur_item.kind;
          s_axis_tvalid <= 1'b1;
          if ($urandom_range(0, 29) == 0) sender_burst = ~sender_burst;
          send_gap <= draw_wait(sender_burst);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stalls, checks each result beat in order.
  always @(posedge clk) begin
    lookup_result_t want;
    int next_stall;
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall <= 0;
    end else begin
      next_stall = sink_stall > 0 ? sink_stall - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        status_seen[m_axis_tdata[1:0]]++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("Unexpected result beat: status %0d id %0d",
                     m_axis_tdata[1:0], m_axis_tdata[13:2]);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[1:0] !== want.status || m_axis_tdata[13:2] !== want.id) begin
            errors++;
            if (errors <= 10)
              $display("Result mismatch: expected status %0d id %0d, got status %0d id %0d",
                       want.status, want.id, m_axis_tdata[1:0], m_axis_tdata[13:2]);
          end
        end
        if ($urandom_range(0, 29) == 0) sink_burst = ~sink_burst;
        next_stall = draw_wait(sink_burst);
      end
      sink_stall <= next_stall;
      m_axis_tready <= (next_stall == 0);
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // One register write beat; the mirror follows at the handshake.
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ghpd_pkg::REG_ORIGIN_X:  org_x = val;
      ghpd_pkg::REG_ORIGIN_Y:  org_y = val;
      ghpd_pkg::REG_ORIGIN_Z:  org_z = val;
      ghpd_pkg::REG_SCALE_X:   scl_x = val;
      ghpd_pkg::REG_SCALE_Y:   scl_y = val;
      ghpd_pkg::REG_SCALE_Z:   scl_z = val;
      ghpd_pkg::REG_TOLERANCE: tol = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                          logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                          logic [31:0] t);
    write_reg(ghpd_pkg::REG_ORIGIN_X, ox);
    write_reg(ghpd_pkg::REG_ORIGIN_Y, oy);
    write_reg(ghpd_pkg::REG_ORIGIN_Z, oz);
    write_reg(ghpd_pkg::REG_SCALE_X, sx);
    write_reg(ghpd_pkg::REG_SCALE_Y, sy);
    write_reg(ghpd_pkg::REG_SCALE_Z, sz);
    write_reg(ghpd_pkg::REG_TOLERANCE, t);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender back until every result is in and the block has settled.
  task automatic drain();
    while (pending_items.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push_item(logic kind, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_item_t it;
    it.kind = kind;
    it.x = x;
    it.y = y;
    it.z = z;
    pending_items.push_back(it);
    if (kind == ghpd_pkg::KIND_INSERT) known_points.push_back(it);
  endtask

  // Coordinate near the grid origin, in a hot cell, or anywhere at all.
  function automatic logic [31:0] pick_coord(logic signed [31:0] org, int mode);
    case (mode)
      0: return $urandom();
      1: return org + 32'h18000 + $urandom_range(0, 16'hFFFF);
      default: return org + $urandom_range(0, 32'h13FFFF) - 32'h20000;
    endcase
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] c);
    int span;
    span = tol == 0 ? 1 : int'(tol);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  // Mostly inserts and repeats of stored points, with near copies and noise.
  task automatic random_items(int n);
    point_item_t p;
    int pick, mode;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      mode = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 2) == 0 ? 1 : 2);
      if (pick < 35 || known_points.size() == 0)
        push_item(ghpd_pkg::KIND_INSERT, pick_coord(org_x, mode), pick_coord(org_y, mode),
                  pick_coord(org_z, mode));
      else if (pick < 55) begin
        p = known_points[$urandom_range(0, known_points.size() - 1)];
        push_item(ghpd_pkg::KIND_INSERT, jitter(p.x), jitter(p.y), jitter(p.z));
      end else if (pick < 85) begin
        p = known_points[$urandom_range(0, known_points.size() - 1)];
        push_item(ghpd_pkg::KIND_QUERY, p.x, p.y, p.z);
      end else if (pick < 93) begin
        p = known_points[$urandom_range(0, known_points.size() - 1)];
        push_item(ghpd_pkg::KIND_QUERY, p.x + $urandom_range(0, 1) * 2 - 1, p.y, p.z);
      end else
        push_item(ghpd_pkg::KIND_QUERY, pick_coord(org_x, mode), pick_coord(org_y, mode),
                  pick_coord(org_z, mode));
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default grid: extremes, exact queries, and one bucket filled past capacity.
    write_reg(REG_UNUSED, 32'hFFFFFFFF);
    cfg_valid <= 1'b0;
    push_item(ghpd_pkg::KIND_INSERT, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_item(ghpd_pkg::KIND_INSERT, 32'h80000000, 32'h80000000, 32'h80000000);
    push_item(ghpd_pkg::KIND_QUERY, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    push_item(ghpd_pkg::KIND_QUERY, 32'h80000000, 32'h80000000, 32'h80000001);
    push_item(ghpd_pkg::KIND_INSERT, 32'h80000000, 32'h80000000, 32'h80000000);
    push_item(ghpd_pkg::KIND_QUERY, 32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 9; i++)
      push_item(ghpd_pkg::KIND_INSERT, 32'h28000 + i, 32'h30000, 32'h50000);
    push_item(ghpd_pkg::KIND_QUERY, 32'h28003, 32'h30000, 32'h50000);
    push_item(ghpd_pkg::KIND_INSERT, 32'h28003, 32'h30000, 32'h50000);
    push_item(ghpd_pkg::KIND_QUERY, 32'h28008, 32'h30000, 32'h50000);
    push_item(ghpd_pkg::KIND_INSERT, 32'h55555555, 32'hAAAAAAAA, 32'h0000FFFF);
    random_items(90);
    drain();

    // Wide tolerance, negative origins, zero scale on x, fine scale on y.
    set_grid(32'hFFF80000, 32'hFFFF0000, 32'hFFFC0000, 32'h0, 32'h80000, 32'h10000,
             32'hFFFF);
    random_items(120);
    drain();

    // Zero tolerance and extreme origins and scales.
    set_grid(32'h80000000, 32'h7FFFFFFF, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h1, 32'h0);
    random_items(120);
    drain();

    // Moderate tolerance on a finer grid.
    set_grid(32'h0, 32'h10000, 32'hFFFF0000, 32'h40000, 32'h20000, 32'h30000, 32'h100);
    random_items(120);
    drain();

    $display("Sent %0d items over four grid settings; %0d points stored.", sent, next_id);
    $display("Results: %0d found, %0d inserted, %0d missed, %0d full.",
             status_seen[ghpd_pkg::ST_FOUND], status_seen[ghpd_pkg::ST_INSERTED],
             status_seen[ghpd_pkg::ST_MISS], status_seen[ghpd_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
